### rtl/core/kvt_pkg.sv
// Package for the key/value table with byte budget.
// Holds widths, op and status codes, the entry layout and the
// structs passed between the engine, the entry RAM and the top level.
package kvt_pkg;

    localparam int SLOTS     = 64;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int CNT_BITS  = $clog2(SLOTS + 1);
    localparam int KEY_BITS  = 64;
    localparam int SIZE_BITS = 24;
    localparam int OP_BITS   = 2;
    localparam int STAT_BITS = 3;
    localparam int CTR_BITS  = 32;

    // request kinds
    localparam logic [OP_BITS-1:0] OP_SET = 2'd0;
    localparam logic [OP_BITS-1:0] OP_GET = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DEL = 2'd2;

    // status codes
    localparam logic [STAT_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_OVER_BUDG = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STAT_BITS-1:0] ST_BUF_SMALL = 3'd5;

    // one stored entry
    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] offset;
    } entry_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        entry_t               data;
    } ram_wr_t;

    // one result item
    typedef struct packed {
        logic [CTR_BITS-1:0]  misses;
        logic [CTR_BITS-1:0]  hits;
        logic [CNT_BITS-1:0]  live_entries;
        logic [SIZE_BITS-1:0] bytes_in_use;
        logic [SIZE_BITS-1:0] value_length;
        logic [SIZE_BITS-1:0] value_offset;
        logic [SLOT_BITS-1:0] slot;
        logic                 found;
        logic [STAT_BITS-1:0] status;
    } result_t;

    localparam int RES_BITS  = $bits(result_t);
    localparam int M_DATA_W  = ((RES_BITS + 7) / 8) * 8;
    localparam int S_DATA_W  = ((KEY_BITS + SIZE_BITS + 7) / 8) * 8;

endpackage

### rtl/core/kvt_ram.sv
// Entry RAM: one write port, one read port, registered read data.
// Depends on kvt_pkg for the entry layout and depth.
module kvt_ram (
    input  logic             aclk,
    input  kvt_pkg::ram_rd_t rd,
    output kvt_pkg::entry_t  rd_data,
    input  kvt_pkg::ram_wr_t wr
);

    kvt_pkg::entry_t mem [kvt_pkg::SLOTS];
    kvt_pkg::entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/kvt_engine.sv
// Request engine: scans the entry RAM for key match and first free slot,
// then executes set/get/delete and updates counters and valid bits.
// Depends on kvt_pkg and drives kvt_ram through its port structs.
module kvt_engine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [kvt_pkg::SIZE_BITS-1:0]    cfg_wdata,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [kvt_pkg::OP_BITS-1:0]      req_op,
    input  logic [kvt_pkg::KEY_BITS-1:0]     req_key,
    input  logic [kvt_pkg::SIZE_BITS-1:0]    req_size,
    output logic                             res_valid,
    input  logic                             res_ready,
    output kvt_pkg::result_t                 res,
    output kvt_pkg::ram_rd_t                 ram_rd,
    input  kvt_pkg::entry_t                  ram_rdata,
    output kvt_pkg::ram_wr_t                 ram_wr
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        EXEC
    } state_t;

    state_t                          state_reg;
    logic [kvt_pkg::CNT_BITS-1:0]    cnt_reg;
    logic                            chk_vld_reg;
    logic [kvt_pkg::SLOT_BITS-1:0]   chk_idx_reg;
    logic [kvt_pkg::OP_BITS-1:0]     op_reg;
    logic [kvt_pkg::KEY_BITS-1:0]    key_reg;
    logic [kvt_pkg::SIZE_BITS-1:0]   size_reg;
    logic                            hit_reg;
    logic [kvt_pkg::SLOT_BITS-1:0]   hit_idx_reg;
    logic [kvt_pkg::SIZE_BITS-1:0]   hit_size_reg;
    logic [kvt_pkg::SIZE_BITS-1:0]   hit_off_reg;
    logic                            free_reg;
    logic [kvt_pkg::SLOT_BITS-1:0]   free_idx_reg;
    logic [kvt_pkg::SLOTS-1:0]       valid_reg;
    logic [kvt_pkg::SIZE_BITS-1:0]   used_reg;
    logic [kvt_pkg::CNT_BITS-1:0]    entries_reg;
    logic [kvt_pkg::CTR_BITS-1:0]    hits_reg;
    logic [kvt_pkg::CTR_BITS-1:0]    misses_reg;
    logic [kvt_pkg::SIZE_BITS-1:0]   budget_reg;

    logic [kvt_pkg::SIZE_BITS-1:0]   used_next;
    logic [kvt_pkg::CNT_BITS-1:0]    entries_next;
    logic [kvt_pkg::CTR_BITS-1:0]    hits_next;
    logic [kvt_pkg::CTR_BITS-1:0]    misses_next;
    logic                            set_valid;
    logic                            clr_valid;
    logic                            done;
    logic                            is_match;
    logic                            is_free;

    assign req_ready = (state_reg == IDLE);
    assign res_valid = (state_reg == EXEC);
    assign done      = res_valid && res_ready;

    // scan compare on the entry returned by the RAM
    assign is_match = chk_vld_reg && valid_reg[chk_idx_reg] && (ram_rdata.key == key_reg);
    assign is_free  = chk_vld_reg && !valid_reg[chk_idx_reg];

    // read address sweep
    always_comb begin
        ram_rd.en   = (state_reg == SCAN) && (cnt_reg < kvt_pkg::CNT_BITS'(kvt_pkg::SLOTS));
        ram_rd.addr = cnt_reg[kvt_pkg::SLOT_BITS-1:0];
    end

    // request execution from scan results
    always_comb begin
        logic [kvt_pkg::SIZE_BITS+1:0] grow_sum;
        logic [kvt_pkg::SIZE_BITS:0]   new_sum;
        logic [kvt_pkg::SIZE_BITS+1:0] budget_x;

        grow_sum = {2'b00, used_reg} + {2'b00, size_reg} - {2'b00, hit_size_reg};
        new_sum  = {1'b0, used_reg} + {1'b0, size_reg};
        budget_x = {2'b00, budget_reg};

        res.status       = kvt_pkg::ST_OK;
        res.found        = hit_reg;
        res.slot         = hit_reg ? hit_idx_reg : '0;
        res.value_offset = hit_reg ? hit_off_reg : '0;
        res.value_length = hit_reg ? hit_size_reg : '0;
        used_next        = used_reg;
        entries_next     = entries_reg;
        hits_next        = hits_reg;
        misses_next      = misses_reg;
        set_valid        = 1'b0;
        clr_valid        = 1'b0;
        ram_wr.en        = 1'b0;
        ram_wr.addr      = hit_idx_reg;
        ram_wr.data.key    = key_reg;
        ram_wr.data.size   = size_reg;
        ram_wr.data.offset = hit_off_reg;

        case (op_reg)
            kvt_pkg::OP_SET: begin
                if (size_reg == '0) begin
                    res.status = kvt_pkg::ST_ZERO_SIZE;
                end else if (hit_reg) begin
                    if ((size_reg > hit_size_reg) && (grow_sum > budget_x)) begin
                        res.status = kvt_pkg::ST_OVER_BUDG;
                    end else begin
                        if (size_reg > hit_size_reg) begin
                            used_next = grow_sum[kvt_pkg::SIZE_BITS-1:0];
                        end
                        res.value_length = size_reg;
                        ram_wr.en        = 1'b1;
                    end
                end else if ({1'b0, new_sum} > budget_x) begin
                    res.status = kvt_pkg::ST_OVER_BUDG;
                end else if (!free_reg) begin
                    res.status = kvt_pkg::ST_FULL;
                end else begin
                    // allocate at the current end of used storage
                    res.slot           = free_idx_reg;
                    res.value_offset   = used_reg;
                    res.value_length   = size_reg;
                    ram_wr.en          = 1'b1;
                    ram_wr.addr        = free_idx_reg;
                    ram_wr.data.offset = used_reg;
                    used_next          = new_sum[kvt_pkg::SIZE_BITS-1:0];
                    entries_next       = entries_reg + 1'b1;
                    set_valid          = 1'b1;
                end
            end
            kvt_pkg::OP_GET: begin
                if (!hit_reg) begin
                    res.status  = kvt_pkg::ST_NOT_FOUND;
                    misses_next = misses_reg + 1'b1;
                end else if (size_reg < hit_size_reg) begin
                    res.status = kvt_pkg::ST_BUF_SMALL;
                end else begin
                    hits_next = hits_reg + 1'b1;
                end
            end
            kvt_pkg::OP_DEL: begin
                if (!hit_reg) begin
                    res.status = kvt_pkg::ST_NOT_FOUND;
                end else begin
                    used_next        = (used_reg >= hit_size_reg) ? used_reg - hit_size_reg : '0;
                    entries_next     = (entries_reg != '0) ? entries_reg - 1'b1 : entries_reg;
                    clr_valid        = 1'b1;
                    res.value_length = '0;
                end
            end
            default: begin
                res.status       = kvt_pkg::ST_NOT_FOUND;
                res.found        = 1'b0;
                res.slot         = '0;
                res.value_offset = '0;
                res.value_length = '0;
            end
        endcase

        ram_wr.en        = ram_wr.en && done;
        res.bytes_in_use = used_next;
        res.live_entries = entries_next;
        res.hits         = hits_next;
        res.misses       = misses_next;
    end

    // sequencer, scan bookkeeping and table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
            valid_reg   <= '0;
            used_reg    <= '0;
            entries_reg <= '0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            budget_reg  <= '0;
        end else begin
            if (cfg_we) begin
                budget_reg <= cfg_wdata;
            end
            chk_vld_reg <= ram_rd.en;
            chk_idx_reg <= ram_rd.addr;
            case (state_reg)
                IDLE: begin
                    if (req_valid) begin
                        op_reg    <= req_op;
                        key_reg   <= req_key;
                        size_reg  <= req_size;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= SCAN;
                    end
                end
                SCAN: begin
                    if (is_match && !hit_reg) begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= chk_idx_reg;
                        hit_size_reg <= ram_rdata.size;
                        hit_off_reg  <= ram_rdata.offset;
                    end
                    if (is_free && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= chk_idx_reg;
                    end
                    if (cnt_reg == kvt_pkg::CNT_BITS'(kvt_pkg::SLOTS)) begin
                        state_reg <= EXEC;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                EXEC: begin
                    if (done) begin
                        used_reg    <= used_next;
                        entries_reg <= entries_next;
                        hits_reg    <= hits_next;
                        misses_reg  <= misses_next;
                        if (set_valid) begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                        if (clr_valid) begin
                            valid_reg[hit_idx_reg] <= 1'b0;
                        end
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/key_value_table_with_budget.sv
// Key/value table with byte budget, top level; uses kvt_pkg, kvt_ram, kvt_engine.
// A request is taken only while the engine is idle; the engine then scans
// all 64 slots over the entry RAM's single read port, then an execute state
// loads the output register. A new request is accepted only after the
// result has left the engine; a stalled result holds the engine.
// Reset (aresetn, synchronous): all slots free, counters and budget zero.
module key_value_table_with_budget (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [kvt_pkg::SIZE_BITS-1:0] cfg_wdata,    // memory_budget
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key [63:0], request_size [87:64]
    input  logic [kvt_pkg::S_DATA_W-1:0]  s_tdata,
    // op [1:0]
    input  logic [kvt_pkg::OP_BITS-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [2:0], found [3], slot [9:4], value_offset [33:10],
    // value_length [57:34], bytes_in_use [81:58], live_entries [88:82],
    // hits [120:89], misses [152:121], zero pad [159:153]
    output logic [kvt_pkg::M_DATA_W-1:0]  m_tdata
);

    kvt_pkg::ram_rd_t ram_rd;
    kvt_pkg::ram_wr_t ram_wr;
    kvt_pkg::entry_t  ram_rdata;
    kvt_pkg::result_t res;
    logic             res_valid;
    logic             res_ready;

    logic             m_tvalid_reg;
    kvt_pkg::result_t m_res_reg;

    kvt_ram u_ram (
        .aclk    (aclk),
        .rd      (ram_rd),
        .rd_data (ram_rdata),
        .wr      (ram_wr)
    );

    kvt_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (s_tuser),
        .req_key   (s_tdata[kvt_pkg::KEY_BITS-1:0]),
        .req_size  (s_tdata[kvt_pkg::KEY_BITS +: kvt_pkg::SIZE_BITS]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_rd    (ram_rd),
        .ram_rdata (ram_rdata),
        .ram_wr    (ram_wr)
    );

    // output register, refilled when empty or being taken
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
            m_res_reg    <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = kvt_pkg::M_DATA_W'(m_res_reg);

endmodule
